### hdl/subframe_walk_crc_check_top_macros.svh
// Assertion macros for the block walk CRC checker.
`ifndef SUBFRAME_WALK_CRC_CHECK_TOP_MACROS_SVH
`define SUBFRAME_WALK_CRC_CHECK_TOP_MACROS_SVH

// Checked outside reset.
`define SCWC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scwc assertion failed");

// Checked at every edge, reset included.
`define SCWC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scwc assertion failed");

`endif

### hdl/scwc_pkg.sv
// Package for the block walk CRC checker: word types, phases, constants.
package scwc_pkg;

   localparam int BASE_LEN       = 263;
   localparam int EXTRA_LEN      = 198;
   localparam int BLOCK_OVERHEAD = 4;
   localparam int POS_W          = 10;

   localparam logic [POS_W-1:0] LIMIT_BASE = POS_W'(BASE_LEN);
   localparam logic [POS_W-1:0] LIMIT_EXT  = POS_W'(BASE_LEN + EXTRA_LEN);
   localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
   localparam logic [15:0]      CRC_INIT   = 16'hFFFF;
   localparam logic [15:0]      CRC_POLY   = 16'h1021;

   typedef enum logic [2:0] {
      PH_STOPPED = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC_LO  = 3'd4,
      PH_CRC_HI  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       first_byte;
      logic       extended;
   } req_type;

   typedef struct packed {
      logic [7:0] block_type;
      logic [7:0] block_len;
      logic [8:0] block_offset;
      logic       crc_ok;
   } rsp_type;

endpackage

### hdl/scwc_crc.sv
// Bytewise CRC-16/CCITT-FALSE update, MSB first.
module scwc_crc import scwc_pkg::*; (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

### hdl/subframe_walk_crc_check_top.sv
// Top level of the block walk CRC checker.
//
//   channel  dir  word      handshake
//   req_     in   req_type  req_valid / req_stall
//   rsp_     out  rsp_type  rsp_valid / rsp_stall
//
// One byte per cycle while req_stall is low; the bytewise CRC update and header
// bookkeeping are combinational between the walk registers. An output register
// plus a one-word skid stage hold results; the result of the high CRC byte of
// a block is registered into the free one; req_stall rises only when both are full.
// Reset is synchronous and clears the walk to stopped with no result pending.
module subframe_walk_crc_check_top import scwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   phase_type        phase_ff, phase_in, cur_phase;
   logic [POS_W-1:0] pos_ff, pos_in, cur_pos;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] limit_ff, limit_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       left_ff, left_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [15:0]      crc_ff, crc_in, crc_upd;
   logic [POS_W:0]   end_sum;
   logic             len_stop;
   logic             accept;
   logic             res_valid;
   rsp_type          res_data;

   logic             out_valid_ff, skid_valid_ff;
   rsp_type          out_data_ff, skid_data_ff;
   logic             drain;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign drain     = out_valid_ff && !rsp_stall;

   scwc_crc u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_data.frame_byte),
      .crc_next  (crc_upd)
   );

   assign cur_phase = req_data.first_byte ? PH_TYPE : phase_ff;
   assign cur_pos   = req_data.first_byte ? '0 : pos_ff;
   assign end_sum   = {1'b0, start_ff} + (POS_W+1)'(req_data.frame_byte)
                      + (POS_W+1)'(BLOCK_OVERHEAD);
   assign len_stop  = (req_data.frame_byte == 8'h00) || (end_sum >= {1'b0, limit_ff});

   // next phase
   always_comb begin
      unique case (cur_phase)
         PH_TYPE:    phase_in = PH_LEN;
         PH_LEN:     phase_in = len_stop ? PH_STOPPED : PH_PAYLOAD;
         PH_PAYLOAD: phase_in = (left_ff == 8'd1) ? PH_CRC_LO : PH_PAYLOAD;
         PH_CRC_LO:  phase_in = PH_CRC_HI;
         PH_CRC_HI:  phase_in = PH_TYPE;
         default:    phase_in = PH_STOPPED;
      endcase
   end

   // datapath and result
   always_comb begin
      pos_in    = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 1'b1;
      limit_in  = req_data.first_byte ? (req_data.extended ? LIMIT_EXT : LIMIT_BASE)
                                      : limit_ff;
      start_in  = start_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res_data.block_type   = type_ff;
      res_data.block_len    = len_ff;
      res_data.block_offset = start_ff[8:0];
      res_data.crc_ok       = ({req_data.frame_byte, crc_lo_ff} == crc_ff);
      unique case (cur_phase)
         PH_TYPE: begin
            type_in  = req_data.frame_byte;
            start_in = cur_pos;
            crc_in   = CRC_INIT;
         end
         PH_LEN: begin
            len_in  = req_data.frame_byte;
            left_in = req_data.frame_byte;
         end
         PH_PAYLOAD: begin
            crc_in  = crc_upd;
            left_in = left_ff - 1'b1;
         end
         PH_CRC_LO: crc_lo_in = req_data.frame_byte;
         PH_CRC_HI: res_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STOPPED;
         pos_ff    <= '0;
         limit_ff  <= LIMIT_BASE;
         start_ff  <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         limit_ff  <= limit_in;
         start_ff  <= start_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   // output register with one-word skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (drain) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || drain) begin
         out_valid_ff <= accept && res_valid;
         out_data_ff  <= res_data;
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= res_data;
      end
   end

endmodule

### hdl/scwc_checker.sv
// Port-level checker for the block walk CRC checker, bound to the top level.
`include "subframe_walk_crc_check_top_macros.svh"

module scwc_checker import scwc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `SCWC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `SCWC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data))
   `SCWC_ASSERT(a_len_nonzero, clock, reset, rsp_valid |-> rsp_data.block_len != 8'h00)
   `SCWC_ASSERT(a_stall_only_full, clock, reset, req_stall |-> rsp_valid)
   `SCWC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind subframe_walk_crc_check_top scwc_checker u_scwc_checker (.*);

### dv/testbench.sv
// Testbench for the block walk CRC checker: byte stimulus, block predictor, result checks.
module testbench;
   import scwc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_req      = 1'b0;
   int hold_left     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;
   int walked_bytes  = 0;
   int blocks_predicted = 0;

   // predicted walk state
   phase_type        wk_phase  = PH_STOPPED;
   logic [POS_W-1:0] wk_pos    = '0;
   logic [POS_W-1:0] wk_start  = '0;
   logic [POS_W-1:0] wk_limit  = LIMIT_BASE;
   logic [7:0]       wk_type   = '0;
   logic [7:0]       wk_len    = '0;
   logic [7:0]       wk_left   = '0;
   logic [7:0]       wk_crc_lo = '0;
   logic [15:0]      wk_crc    = CRC_INIT;

   rsp_type expected_blocks[$];

   subframe_walk_crc_check_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit coin();
      return 1'($urandom_range(1, 0));
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic void walk_predict(input req_type w);
      logic [10:0] blk_end;
      rsp_type     blk;
      if (w.first_byte) begin
         wk_pos   = '0;
         wk_limit = w.extended ? LIMIT_EXT : LIMIT_BASE;
         wk_phase = PH_TYPE;
      end
      if (wk_phase != PH_STOPPED)
         walked_bytes++;
      case (wk_phase)
         PH_TYPE: begin
            wk_type  = w.frame_byte;
            wk_start = wk_pos;
            wk_crc   = CRC_INIT;
            wk_phase = PH_LEN;
         end
         PH_LEN: begin
            blk_end = 11'(wk_start) + 11'(w.frame_byte) + 11'(BLOCK_OVERHEAD);
            wk_len  = w.frame_byte;
            wk_left = w.frame_byte;
            if (w.frame_byte == 8'd0 || blk_end >= 11'(wk_limit))
               wk_phase = PH_STOPPED;
            else
               wk_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            wk_crc  = crc16_byte(wk_crc, w.frame_byte);
            wk_left = wk_left - 8'd1;
            if (wk_left == 8'd0)
               wk_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            wk_crc_lo = w.frame_byte;
            wk_phase  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            blk.block_type   = wk_type;
            blk.block_len    = wk_len;
            blk.block_offset = wk_start[8:0];
            blk.crc_ok       = ({w.frame_byte, wk_crc_lo} == wk_crc);
            expected_blocks.push_back(blk);
            blocks_predicted++;
            wk_phase = PH_TYPE;
         end
         default: wk_phase = PH_STOPPED;
      endcase
      if (wk_pos != POS_MAX)
         wk_pos = wk_pos + 1'b1;
   endfunction

   // result side: stall pattern, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result word %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_data.block_type !== want.block_type) begin
               $error("block_type: expected %0d, got %0d", want.block_type, rsp_data.block_type);
               fail_count++;
            end
            if (rsp_data.block_len !== want.block_len) begin
               $error("block_len: expected %0d, got %0d", want.block_len, rsp_data.block_len);
               fail_count++;
            end
            if (rsp_data.block_offset !== want.block_offset) begin
               $error("block_offset: expected %0d, got %0d", want.block_offset,
                      rsp_data.block_offset);
               fail_count++;
            end
            if (rsp_data.crc_ok !== want.crc_ok) begin
               $error("crc_ok: expected %0d, got %0d", want.crc_ok, rsp_data.crc_ok);
               fail_count++;
            end
         end
      end
   end

   task automatic offer_byte(input logic [7:0] data, input bit first, input bit ext);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{frame_byte: data, first_byte: first, extended: ext};
      do @(posedge clock); while (req_stall);
      walk_predict(req_data);
   endtask

   task automatic send_block(input logic [7:0] btype, input logic [7:0] blen, input bit good,
                             input bit first, input bit ext);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = CRC_INIT;
      offer_byte(btype, first, ext);
      offer_byte(blen, 1'b0, coin());
      if (wk_phase != PH_PAYLOAD)
         return;
      repeat (blen) begin
         b   = 8'($urandom);
         crc = crc16_byte(crc, b);
         offer_byte(b, 1'b0, coin());
      end
      if (!good)
         crc ^= 16'(1) << $urandom_range(15, 0);
      offer_byte(crc[7:0], 1'b0, coin());
      offer_byte(crc[15:8], 1'b0, coin());
   endtask

   // long_walk keeps adding blocks until the data limit ends the frame
   task automatic random_frame(input bit long_walk);
      bit               ext, first;
      int               nblk, room, ln;
      logic [POS_W-1:0] lim, pos;
      ext   = coin();
      first = 1'b1;
      nblk  = long_walk ? 200 : $urandom_range(4, 1);
      for (int k = 0; k < nblk; k++) begin
         lim  = first ? (ext ? LIMIT_EXT : LIMIT_BASE) : wk_limit;
         pos  = first ? '0 : wk_pos;
         room = int'(lim) - int'(pos) - BLOCK_OVERHEAD;
         if (room <= 48 && coin())
            ln = room - 1 + int'($urandom_range(2, 0));
         else if ($urandom_range(19, 0) == 0)
            ln = $urandom_range(255, 100);
         else
            ln = $urandom_range(12, 1);
         if (ln < 1)
            ln = 1;
         if (ln > 255)
            ln = 255;
         send_block(8'($urandom), 8'(ln), $urandom_range(4, 0) != 0, first, ext);
         first = 1'b0;
         if (wk_phase == PH_STOPPED)
            return;
      end
      if (long_walk)
         return;
      case ($urandom_range(2, 0))
         0: begin
            offer_byte(8'($urandom), 1'b0, coin());
            offer_byte(8'h00, 1'b0, coin());
         end
         1: ;
         default: begin
            ln = $urandom_range(12, 2);
            offer_byte(8'($urandom), 1'b0, coin());
            offer_byte(8'(ln), 1'b0, coin());
            repeat ($urandom_range(ln - 1, 0))
               offer_byte(8'($urandom), 1'b0, coin());
         end
      endcase
   endtask

   task automatic test_bytes_before_frame();
      offer_byte(8'hFF, 1'b0, 1'b1);
      offer_byte(8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_block_chain();
      send_block(8'h00, 8'd1, 1'b1, 1'b1, 1'b0);
      send_block(8'hFF, 8'd2, 1'b0, 1'b0, 1'b0);
      offer_byte(8'h5A, 1'b0, 1'b1);
      offer_byte(8'h00, 1'b0, 1'b0);
      offer_byte(8'hC3, 1'b0, 1'b1);
   endtask

   task automatic test_new_frame_mid_block();
      offer_byte(8'h7E, 1'b1, 1'b1);
      offer_byte(8'h03, 1'b0, 1'b0);
      offer_byte(8'h11, 1'b0, 1'b0);
      send_block(8'h80, 8'd1, 1'b1, 1'b1, 1'b1);
   endtask

   // second block ends exactly on the base limit
   task automatic test_limit_equal();
      send_block(8'h21, 8'd1, 1'b1, 1'b1, 1'b0);
      offer_byte(8'h22, 1'b0, 1'b0);
      offer_byte(8'd254, 1'b0, 1'b1);
      offer_byte(8'h33, 1'b0, 1'b0);
   endtask

   task automatic random_walk(input int byte_goal, input int block_goal);
      int byte_end, block_end;
      byte_end  = walked_bytes + byte_goal;
      block_end = blocks_predicted + block_goal;
      while (walked_bytes < byte_end || blocks_predicted < block_end) begin
         case ($urandom_range(11, 0))
            0: repeat ($urandom_range(6, 1))
                  offer_byte(8'($urandom), $urandom_range(7, 0) == 0, coin());
            1: random_frame(1'b1);
            default: random_frame(1'b0);
         endcase
      end
   endtask

   // result side held off while small blocks keep coming
   task automatic test_output_holdoff();
      hold_req = 1'b1;
      for (int k = 0; k < 12; k++)
         send_block(8'($urandom), 8'($urandom_range(3, 1)), coin(), k == 0, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 71;
      test_bytes_before_frame();
      test_block_chain();
      test_new_frame_mid_block();
      test_limit_equal();
      random_walk(80, 5);

      send_idle_pct = 71;
      recv_idle_pct = 25;
      random_walk(80, 5);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_walk(80, 5);
      test_output_holdoff();

      req_valid <= 1'b0;
      while (expected_blocks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/scwc_pkg.sv
hdl/scwc_crc.sv
hdl/subframe_walk_crc_check_top.sv
hdl/scwc_checker.sv
dv/testbench.sv
